>>> rtl/sspq_pkg.sv
// Shared types and constants for the stable sorted priority queue.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package sspq_pkg;

    // Storage geometry
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Depth of the queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Request codes on the input channel
    localparam logic [1:0] REQ_ENQ = 2'd0;
    localparam logic [1:0] REQ_DEQ = 2'd1;
    localparam logic [1:0] REQ_CLR = 2'd2;

    // Classified operation
    typedef enum logic [1:0] {
        OP_ENQ,
        OP_DEQ,
        OP_CLR,
        OP_NOP
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One classified request as it travels from front to back
    typedef struct packed {
        t_op                   op;
        logic [DATA_WIDTH-1:0] value;
        logic [7:0]            prio;
    } t_req;

endpackage
`default_nettype wire

>>> rtl/stable_sorted_priority_queue.sv
// Top level of the stable sorted priority queue.
// Depends on sspq_pkg, sspq_front, sspq_queue and sspq_back.
//
// Usage:
//   Input channel i_valid / o_stall carries one request item: enqueue a
//   word with a priority, dequeue the head, or clear. Lower priority
//   numbers leave first; equal priorities leave in arrival order.
//   Output channel o_valid / i_stall carries exactly one result item per
//   request: status, removed word, head word and priority, count, flags.
//   An accepted request is first written into the request queue; the cell
//   chain then works on it from the queue head and the result register
//   loads its result, unless a receiver stall holds it in the queue.
//   Throughput: one item per cycle unless the receiver stalls; every cell
//   compares with the new priority in the same cycle, shifting in one step.
//   Reset clears the entry count, the request queue and the result valid.
//   While the receiver stalls, the result register holds and the two-entry
//   request queue keeps taking items until full, then o_stall rises.
`default_nettype none
module stable_sorted_priority_queue import sspq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_item_value,
    input  wire logic [7:0]  i_item_priority,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [31:0]      o_removed_value,
    output logic [31:0]      o_head_value,
    output logic [7:0]       o_head_priority,
    output logic [4:0]       o_entry_count,
    output logic             o_is_empty,
    output logic             o_is_full
);

    logic    push;
    t_req    front_req;
    logic    q_full;
    logic    q_valid;
    t_req    q_req;
    logic    q_pop;
    t_status status;

    sspq_front u_front (
        .i_valid         (i_valid),
        .i_req_type      (i_req_type),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .i_full          (q_full),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_req           (front_req)
    );

    sspq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_req   (q_req),
        .o_full  (q_full)
    );

    sspq_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (q_valid),
        .i_req           (q_req),
        .o_pop           (q_pop),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (status),
        .o_removed_value (o_removed_value),
        .o_head_value    (o_head_value),
        .o_head_priority (o_head_priority),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_is_full       (o_is_full)
    );

    assign o_status = status;

    // Count never exceeds capacity and the flags agree with it
    a_count_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_entry_count <= 5'(CAPACITY))
                    && (o_is_empty == (o_entry_count == 5'd0)))
        else $error("entry count and flags disagree");

    // A dropped enqueue only happens on a full queue
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && status == ST_FULL) |-> o_is_full)
        else $error("enqueue dropped while not full");

    // An empty queue reports a zero head
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_empty) |-> (o_head_value == 32'd0 && o_head_priority == 8'd0))
        else $error("empty queue shows a head entry");

    // A stalled result keeps its count until taken
    a_hold_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_entry_count) && $stable(status)))
        else $error("stalled result changed");

endmodule
`default_nettype wire

>>> rtl/sspq_front.sv
// Front end: decodes the request code into an operation and packs the item.
// Depends on sspq_pkg.
`default_nettype none
module sspq_front import sspq_pkg::*; (
    input  wire logic        i_valid,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [31:0] i_item_value,
    input  wire logic [7:0]  i_item_priority,
    input  wire logic        i_full,
    output logic             o_stall,
    output logic             o_push,
    output t_req             o_req
);

    // Classify the request; the unused code becomes a no-op
    always_comb begin
        o_req.value = DATA_WIDTH'(i_item_value);
        o_req.prio  = i_item_priority;
        unique case (i_req_type)
            REQ_ENQ: o_req.op = OP_ENQ;
            REQ_DEQ: o_req.op = OP_DEQ;
            REQ_CLR: o_req.op = OP_CLR;
            default: o_req.op = OP_NOP;
        endcase
    end

    // Hold the sender off while the queue is full
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule
`default_nettype wire

>>> rtl/sspq_queue.sv
// Short request queue that decouples the front end from the sorted store.
// Depends on sspq_pkg.
`default_nettype none
module sspq_queue import sspq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_req,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_req      o_req,
    output logic      o_full
);

    t_req              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_req   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // Advance pointers with wrap and track occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule
`default_nettype wire

>>> rtl/sspq_back.sv
// Back end: sorted cell chain that inserts, removes and clears entries,
// plus the result register. Depends on sspq_pkg.
`default_nettype none
module sspq_back import sspq_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_req        i_req,
    output logic             o_pop,
    input  wire logic        i_stall,
    output logic             o_valid,
    output t_status          o_status,
    output logic [31:0]      o_removed_value,
    output logic [31:0]      o_head_value,
    output logic [7:0]       o_head_priority,
    output logic [4:0]       o_entry_count,
    output logic             o_is_empty,
    output logic             o_is_full
);

    logic [DATA_WIDTH-1:0] r_val [CAPACITY];
    logic [DATA_WIDTH-1:0] n_val [CAPACITY];
    logic [7:0]            r_pri [CAPACITY];
    logic [7:0]            n_pri [CAPACITY];
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CAPACITY-1:0]   le;
    logic [CAPACITY-1:0]   prev_le;
    t_status               res_status;
    logic [DATA_WIDTH-1:0] res_removed;
    logic                  execute;

    // Take the next request when the result register is free or draining
    assign execute = i_valid && (!o_valid || !i_stall);
    assign o_pop   = execute;

    // Per-cell compare: held and not after the new item in service order
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            le[k] = (CNT_W'(k) < r_count) && (r_pri[k] <= i_req.prio);
        end
        prev_le[0] = 1'b1;
        for (int k = 1; k < CAPACITY; k++) begin
            prev_le[k] = le[k-1];
        end
    end

    // Next state of the cell chain
    always_comb begin
        n_val       = r_val;
        n_pri       = r_pri;
        n_count     = r_count;
        res_status  = ST_OK;
        res_removed = '0;
        unique case (i_req.op)
            OP_ENQ: begin
                if (r_count == CNT_W'(CAPACITY)) begin
                    res_status = ST_FULL;
                end else begin
                    // head cell takes the new item unless it stays in place
                    if (!le[0]) begin
                        n_val[0] = i_req.value;
                        n_pri[0] = i_req.prio;
                    end
                    for (int k = 1; k < CAPACITY; k++) begin
                        if (!le[k]) begin
                            if (prev_le[k]) begin
                                n_val[k] = i_req.value;
                                n_pri[k] = i_req.prio;
                            end else begin
                                n_val[k] = r_val[k-1];
                                n_pri[k] = r_pri[k-1];
                            end
                        end
                    end
                    n_count = r_count + 1'b1;
                end
            end
            OP_DEQ: begin
                if (r_count == '0) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_removed = r_val[0];
                    for (int k = 0; k < CAPACITY - 1; k++) begin
                        n_val[k] = r_val[k+1];
                        n_pri[k] = r_pri[k+1];
                    end
                    n_count = r_count - 1'b1;
                end
            end
            OP_CLR: begin
                n_count = '0;
            end
            OP_NOP: begin
            end
            default: begin
            end
        endcase
    end

    // Clear the count and result valid under reset; else load the count and set valid on execute, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            if (execute) begin
                r_count <= n_count;
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    // Update cells and capture the result payload
    always_ff @(posedge i_clk) begin
        if (execute) begin
            r_val           <= n_val;
            r_pri           <= n_pri;
            o_status        <= res_status;
            o_removed_value <= 32'(res_removed);
            o_head_value    <= (n_count != '0) ? 32'(n_val[0]) : '0;
            o_head_priority <= (n_count != '0) ? n_pri[0] : '0;
            o_entry_count   <= 5'(n_count);
            o_is_empty      <= (n_count == '0);
            o_is_full       <= (n_count >= CNT_W'(CAPACITY));
        end
    end

endmodule
`default_nettype wire

>>> sim/stable_sorted_priority_queue_tb.sv
// Self-checking testbench for the stable sorted priority queue.
// Depends on sspq_pkg and stable_sorted_priority_queue; a scoreboard class
// predicts each result item from the accepted request items.
`default_nettype none
module stable_sorted_priority_queue_tb;
    import sspq_pkg::*;

    // Request code the block treats as no operation
    localparam logic [1:0] REQ_NONE = 2'd3;

    // One result item as seen on the output channel
    typedef struct {
        t_status     status;
        logic [31:0] removed;
        logic [31:0] head_value;
        logic [7:0]  head_prio;
        logic [4:0]  count;
        logic        empty;
        logic        full;
    } t_outcome;

    // Shadow copy of the sorted store plus the results still owed
    class sorted_queue_ledger;
        logic [31:0] slot_value[CAPACITY];
        logic [7:0]  slot_prio[CAPACITY];
        int unsigned held = 0;
        t_outcome    owed_results[$];
        int unsigned errors = 0;

        // Apply one accepted request and queue the result it must produce
        function void take_request(logic [1:0] req, logic [31:0] value, logic [7:0] prio);
            t_outcome    res;
            int unsigned pos;
            int unsigned k;
            res.status  = ST_OK;
            res.removed = '0;
            case (req)
                REQ_ENQ: begin
                    if (held >= CAPACITY) begin
                        res.status = ST_FULL;
                    end else begin
                        // insert after every entry of lower or equal priority
                        pos = 0;
                        while (pos < held && slot_prio[pos] <= prio) pos++;
                        for (k = held; k > pos; k--) begin
                            slot_value[k] = slot_value[k-1];
                            slot_prio[k]  = slot_prio[k-1];
                        end
                        slot_value[pos] = value;
                        slot_prio[pos]  = prio;
                        held++;
                    end
                end
                REQ_DEQ: begin
                    if (held == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.removed = slot_value[0];
                        for (k = 1; k < held; k++) begin
                            slot_value[k-1] = slot_value[k];
                            slot_prio[k-1]  = slot_prio[k];
                        end
                        held--;
                    end
                end
                REQ_CLR: begin
                    held = 0;
                end
                default: begin
                end
            endcase
            res.head_value = (held > 0) ? slot_value[0] : '0;
            res.head_prio  = (held > 0) ? slot_prio[0] : '0;
            res.count      = 5'(held);
            res.empty      = (held == 0);
            res.full       = (held >= CAPACITY);
            owed_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        // Match one accepted result item against the oldest owed result
        function void match_result(t_outcome got);
            t_outcome want;
            if (owed_results.size() == 0) begin
                $error("result item with no request outstanding");
                errors++;
                return;
            end
            want = owed_results.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("removed_value", want.removed, got.removed);
            compare_field("head_value", want.head_value, got.head_value);
            compare_field("head_priority", 32'(want.head_prio), 32'(got.head_prio));
            compare_field("entry_count", 32'(want.count), 32'(got.count));
            compare_field("is_empty", 32'(want.empty), 32'(got.empty));
            compare_field("is_full", 32'(want.full), 32'(got.full));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_req_type;
    logic [31:0] i_item_value;
    logic [7:0]  i_item_priority;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [31:0] o_removed_value;
    logic [31:0] o_head_value;
    logic [7:0]  o_head_priority;
    logic [4:0]  o_entry_count;
    logic        o_is_empty;
    logic        o_is_full;

    sorted_queue_ledger ledger = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned stall_hold    = 0;

    stable_sorted_priority_queue DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_item_value    (i_item_value),
        .i_item_priority (i_item_priority),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_removed_value (o_removed_value),
        .o_head_value    (o_head_value),
        .o_head_priority (o_head_priority),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_is_full       (o_is_full)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard limit on run time
    initial begin
        #400000;
        $display("stable_sorted_priority_queue_tb: FAIL");
        $finish;
    end

    // Result side: check at the rising edge, decide the stall at the falling edge
    initial begin
        t_outcome got;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.status     = t_status'(o_status);
                got.removed    = o_removed_value;
                got.head_value = o_head_value;
                got.head_prio  = o_head_priority;
                got.count      = o_entry_count;
                got.empty      = o_is_empty;
                got.full       = o_is_full;
                ledger.match_result(got);
            end
            @(negedge i_clk);
            if (stall_hold != 0) begin
                i_stall <= 1'b1;
                stall_hold--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Offer one request item, with random idle cycles ahead of it
    task automatic send_request(input logic [1:0] req, input logic [31:0] value,
                                input logic [7:0] prio);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid         <= 1'b0;
            i_req_type      <= 2'($urandom);
            i_item_value    <= $urandom;
            i_item_priority <= 8'($urandom);
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_req_type      <= req;
        i_item_value    <= value;
        i_item_priority <= prio;
        do @(posedge i_clk); while (o_stall);
        ledger.take_request(req, value, prio);
    endtask

    // Random requests in bursts that fill, drain or churn the queue
    task automatic run_random(input int unsigned total);
        int unsigned left;
        int unsigned burst;
        int unsigned mode;
        int unsigned roll;
        int unsigned enq_pct;
        logic [1:0]  req;
        logic [31:0] value;
        logic [7:0]  prio;
        left = total;
        while (left != 0) begin
            burst = $urandom_range(40, 8);
            if (burst > left) burst = left;
            mode    = $urandom_range(2);
            enq_pct = (mode == 0) ? 80 : (mode == 1) ? 25 : 52;
            repeat (burst) begin
                roll = $urandom_range(99);
                if (roll < 2)             req = REQ_CLR;
                else if (roll < 3)        req = REQ_NONE;
                else if (roll < enq_pct)  req = REQ_ENQ;
                else                      req = REQ_DEQ;
                roll = $urandom_range(99);
                if (roll < 45)      prio = 8'($urandom_range(3));
                else if (roll < 55) prio = $urandom_range(1) ? 8'hFF : 8'h00;
                else                prio = 8'($urandom);
                roll = $urandom_range(99);
                if (roll < 5)       value = 32'h0;
                else if (roll < 10) value = 32'hFFFF_FFFF;
                else                value = $urandom;
                send_request(req, value, prio);
                left--;
            end
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_req_type      = REQ_ENQ;
        i_item_value    = '0;
        i_item_priority = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty cases, extremes, ties, full, clear
        send_request(REQ_DEQ, 32'h1234_5678, 8'h10);
        send_request(REQ_NONE, 32'hDEAD_BEEF, 8'h20);
        send_request(REQ_ENQ, 32'hFFFF_FFFF, 8'hFF);
        send_request(REQ_ENQ, 32'h0000_0000, 8'h00);
        send_request(REQ_DEQ, 32'h0, 8'h0);
        send_request(REQ_CLR, 32'hFFFF_FFFF, 8'hFF);
        for (int n = 0; n < CAPACITY; n++) begin
            case (n % 4)
                0: send_request(REQ_ENQ, 32'h100 + n, 8'h05);
                1: send_request(REQ_ENQ, 32'h100 + n, 8'h00);
                2: send_request(REQ_ENQ, 32'h100 + n, 8'hFF);
                default: send_request(REQ_ENQ, 32'h100 + n, 8'h05);
            endcase
        end
        send_request(REQ_ENQ, 32'hA5A5_A5A5, 8'h00);
        send_request(REQ_NONE, 32'h5A5A_5A5A, 8'h01);
        send_request(REQ_DEQ, 32'h0, 8'h0);
        send_request(REQ_CLR, 32'h0, 8'h0);

        // Random: receiver idles more, then sender idles more, then none
        send_idle_pct = 30;
        recv_idle_pct = 65;
        run_random(430);
        send_idle_pct = 65;
        recv_idle_pct = 30;
        run_random(430);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // long receiver hold-off so the block backs up and stalls its input
        stall_hold = 150;
        run_random(440);

        @(negedge i_clk);
        i_valid <= 1'b0;

        // Drain outstanding results, then allow for the pipeline latency
        while (ledger.owed_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (ledger.errors == 0) begin
            $display("stable_sorted_priority_queue_tb: PASS");
        end else begin
            $display("stable_sorted_priority_queue_tb: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
rtl/sspq_pkg.sv
rtl/sspq_front.sv
rtl/sspq_queue.sv
rtl/sspq_back.sv
rtl/stable_sorted_priority_queue.sv
sim/stable_sorted_priority_queue_tb.sv
